// ===== hdl/leadv_pkg.sv =====
package leadv_pkg;

	// Largest packet that is parsed; later bytes only close the packet.
	localparam int MAX_PACKET = 260;
	localparam int BPOS_W     = $clog2(MAX_PACKET + 1);

	// Header layout and checks.
	localparam int POS_IND     = 0;
	localparam int POS_EVT     = 1;
	localparam int POS_SUB     = 3;
	localparam int POS_NUM     = 4;
	localparam int POS_REPORTS = 5;

	localparam logic [7:0] PKT_EVENT      = 8'h04;
	localparam logic [7:0] EVT_LE_META    = 8'h3E;
	localparam logic [7:0] SUB_ADV_REPORT = 8'h02;
	localparam logic [7:0] MAX_REPORTS    = 8'd15;
	localparam int         MIN_PACKET     = 16;

	// Layout inside one report. The RSSI sits at FP_DATA plus the data
	// length, so the position needs one bit more than a byte.
	localparam int FP_W       = 9;
	localparam int FP_ADV     = 0;
	localparam int FP_ATYPE   = 1;
	localparam int FP_ADDR0   = 2;
	localparam int FP_ADDR_N  = 7;
	localparam int FP_LEN     = 8;
	localparam int FP_DATA    = 9;
	localparam int ADDR_BYTES = 6;

	// Result queue.
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef enum logic [1:0] {
		KIND_DATA    = 2'd0,
		KIND_REPORT  = 2'd1,
		KIND_DISCARD = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t             kind;
		logic [7:0]        data_value;
		logic [3:0]        report_index;
		logic [7:0]        evt_type;
		logic [7:0]        peer_atype;
		logic [47:0]       address;
		logic signed [7:0] rssi;
		logic [7:0]        payload_len;
		logic              run_last;
	} result_t;

endpackage

// ===== hdl/le_adv_report_parser.sv =====
// LE advertising report parser.
// Bytes of received HCI event packets enter on the s_ channel, one per
// transfer, with s_tlast on the final byte of each packet. Results leave on
// the m_ channel: m_tuser gives the kind (provisional data byte, report
// complete, discard the current report's data) and m_tlast marks the last
// result caused by one input byte. The cfg_ channel writes the enable bit;
// every write also clears the packet state. The user must write it only
// while the block is idle; the block itself does not enforce this.
// A byte's results are written into the queue at the edge that takes the
// byte. One byte can be taken every cycle while the queue has room for two
// results; a byte that ends a cut-off report may cause two results, which
// leave as two separate transfers. Results wait in a four-entry queue, and
// s_tready is low while fewer than two entries are free, so a stalled
// receiver stops the input after at most four results are held.
// After reset the parser is disabled (bytes are taken and dropped), the
// packet state is clear and the queue is empty.
module le_adv_report_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data,       // enable
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,        // in_byte
	input  logic        s_tlast,        // in_last
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [95:0] m_tdata,        // data_value, report_index, evt_type, peer_atype,
	                                    // address, rssi, payload_len, zero fill
	output logic [1:0]  m_tuser,        // kind
	output logic        m_tlast         // run_last
);
	import leadv_pkg::*;

	logic       step;
	logic       cfg_we;
	logic       pop;
	logic       space_ok;
	logic [1:0] res_cnt;
	result_t    res0;
	result_t    res1;
	result_t    head;

	assign cfg_ready = 1'b1;
	assign cfg_we    = cfg_valid && cfg_ready;
	assign s_tready  = space_ok;
	assign step      = s_tvalid && s_tready;
	assign pop       = m_tvalid && m_tready;

	leadv_parse u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_enable (cfg_data),
		.step       (step),
		.in_byte    (s_tdata),
		.in_last    (s_tlast),
		.res0       (res0),
		.res1       (res1),
		.res_cnt    (res_cnt)
	);

	leadv_rsq u_rsq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_cnt   (step ? res_cnt : 2'd0),
		.push0      (res0),
		.push1      (res1),
		.pop        (pop),
		.space_ok   (space_ok),
		.head_valid (m_tvalid),
		.head       (head)
	);

	assign m_tdata = {4'd0, head.payload_len, head.rssi, head.address, head.peer_atype,
	                  head.evt_type, head.report_index, head.data_value};
	assign m_tuser = head.kind;
	assign m_tlast = head.run_last;

endmodule

// ===== hdl/leadv_parse.sv =====
module leadv_parse (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic                cfg_enable,
	input  logic                step,
	input  logic [7:0]          in_byte,
	input  logic                in_last,
	output leadv_pkg::result_t  res0,
	output leadv_pkg::result_t  res1,
	output logic [1:0]          res_cnt
);
	import leadv_pkg::*;

	logic              enable_q;
	logic [BPOS_W-1:0] byte_pos_q,  byte_pos_d;
	logic              reject_q,    reject_d;
	logic [3:0]        total_q,     total_d;
	logic [3:0]        num_q,       num_d;
	logic [FP_W-1:0]   field_pos_q, field_pos_d;
	logic              done_q,      done_d;
	logic [7:0]        adv_q,       adv_d;
	logic [7:0]        atype_q,     atype_d;
	logic [47:0]       address_q,   address_d;
	logic [7:0]        len_q,       len_d;

	logic              has0, has1;
	kind_t             kind0;
	logic [7:0]        dv0;
	logic [7:0]        rssi0;
	logic [2:0]        addr_idx;
	result_t           base;

	always_comb begin
		byte_pos_d  = byte_pos_q;
		reject_d    = reject_q;
		total_d     = total_q;
		num_d       = num_q;
		field_pos_d = field_pos_q;
		done_d      = done_q;
		adv_d       = adv_q;
		atype_d     = atype_q;
		address_d   = address_q;
		len_d       = len_q;
		has0        = 1'b0;
		has1        = 1'b0;
		kind0       = KIND_DATA;
		dv0         = 8'd0;
		rssi0       = 8'd0;
		addr_idx    = 3'(field_pos_q - FP_W'(FP_ADDR0));

		if (enable_q) begin
			if (byte_pos_q < BPOS_W'(MAX_PACKET)) begin
				byte_pos_d = byte_pos_q + 1'b1;
				if (!reject_q) begin
					if (byte_pos_q == BPOS_W'(POS_IND)) begin
						reject_d = (in_byte != PKT_EVENT);
					end else if (byte_pos_q == BPOS_W'(POS_EVT)) begin
						reject_d = (in_byte != EVT_LE_META);
					end else if (byte_pos_q == BPOS_W'(POS_SUB)) begin
						reject_d = (in_byte != SUB_ADV_REPORT);
					end else if (byte_pos_q == BPOS_W'(POS_NUM)) begin
						if (in_byte == 8'd0 || in_byte > MAX_REPORTS) begin
							reject_d = 1'b1;
						end else begin
							total_d = in_byte[3:0];
						end
					end else if (byte_pos_q >= BPOS_W'(POS_REPORTS) && !done_q) begin
						field_pos_d = field_pos_q + 1'b1;
						if (field_pos_q == FP_W'(FP_ADV)) begin
							adv_d     = in_byte;
							atype_d   = 8'd0;
							address_d = 48'd0;
							len_d     = 8'd0;
						end else if (field_pos_q == FP_W'(FP_ATYPE)) begin
							atype_d = in_byte;
						end else if (field_pos_q <= FP_W'(FP_ADDR_N)) begin
							for (int i = 0; i < ADDR_BYTES; i++) begin
								if (addr_idx == 3'(i)) begin
									address_d[8*i +: 8] = in_byte;
								end
							end
						end else if (field_pos_q == FP_W'(FP_LEN)) begin
							len_d = in_byte;
						end else if (field_pos_q < FP_W'(FP_DATA) + FP_W'(len_q)) begin
							has0  = 1'b1;
							kind0 = KIND_DATA;
							dv0   = in_byte;
						end else begin
							// RSSI byte: the report is complete, unless a
							// too short packet ends on it.
							has0 = 1'b1;
							if (in_last && byte_pos_q < BPOS_W'(MIN_PACKET - 1)) begin
								kind0 = KIND_DISCARD;
							end else begin
								kind0 = KIND_REPORT;
								rssi0 = in_byte;
							end
							field_pos_d = '0;
							num_d       = num_q + 1'b1;
							if (num_d >= total_q) begin
								done_d = 1'b1;
							end
						end
					end
				end
			end

			if (in_last) begin
				has1 = !reject_d && !done_d && (field_pos_d != '0);
				byte_pos_d  = '0;
				reject_d    = 1'b0;
				total_d     = '0;
				num_d       = '0;
				field_pos_d = '0;
				done_d      = 1'b0;
			end
		end
	end

	always_comb begin
		base              = '0;
		base.report_index = num_q;
		base.evt_type     = adv_d;
		base.peer_atype   = atype_d;
		base.address      = address_d;
		base.payload_len  = len_d;

		res1          = base;
		res1.kind     = KIND_DISCARD;
		res1.run_last = 1'b1;

		if (has0) begin
			res0            = base;
			res0.kind       = kind0;
			res0.data_value = dv0;
			res0.rssi       = rssi0;
			res0.run_last   = !has1;
		end else begin
			res0 = res1;
		end

		res_cnt = {1'b0, has0} + {1'b0, has1};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q    <= 1'b0;
			byte_pos_q  <= '0;
			reject_q    <= 1'b0;
			total_q     <= '0;
			num_q       <= '0;
			field_pos_q <= '0;
			done_q      <= 1'b0;
		end else if (cfg_we) begin
			enable_q    <= cfg_enable;
			byte_pos_q  <= '0;
			reject_q    <= 1'b0;
			total_q     <= '0;
			num_q       <= '0;
			field_pos_q <= '0;
			done_q      <= 1'b0;
		end else if (step) begin
			byte_pos_q  <= byte_pos_d;
			reject_q    <= reject_d;
			total_q     <= total_d;
			num_q       <= num_d;
			field_pos_q <= field_pos_d;
			done_q      <= done_d;
		end
	end

	// Captured report fields carry no reset; they are written before use.
	always_ff @(posedge clk) begin
		if (step && !cfg_we) begin
			adv_q     <= adv_d;
			atype_q   <= atype_d;
			address_q <= address_d;
			len_q     <= len_d;
		end
	end

	// Two results from one byte are always a data byte followed by a discard.
	a_two_results: assert property (@(posedge clk) disable iff (!arst_n)
		(step && res_cnt == 2'd2) |-> (res0.kind == KIND_DATA && res1.kind == KIND_DISCARD))
		else $error("two results from one byte in the wrong order");

	// Once the header has passed, the current report lies within the count.
	a_report_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(!reject_q && !done_q && byte_pos_q > BPOS_W'(POS_REPORTS)) |-> (num_q < total_q))
		else $error("report index beyond announced count");

	// Inside a report the position never passes the RSSI byte.
	a_field_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(field_pos_q > FP_W'(FP_LEN)) |-> (field_pos_q <= FP_W'(FP_DATA) + FP_W'(len_q)))
		else $error("field position past the RSSI byte");

	// A disabled parser keeps its packet state.
	a_disabled_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(step && !enable_q && !cfg_we) |=> $stable(byte_pos_q))
		else $error("packet state moved while disabled");

endmodule

// ===== hdl/leadv_rsq.sv =====
module leadv_rsq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [1:0]          push_cnt,
	input  leadv_pkg::result_t  push0,
	input  leadv_pkg::result_t  push1,
	input  logic                pop,
	output logic                space_ok,
	output logic                head_valid,
	output leadv_pkg::result_t  head
);
	import leadv_pkg::*;

	result_t           q_mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic [QPTR_W-1:0] wr_ptr_nx;

	assign wr_ptr_nx  = wr_ptr_q + 1'b1;
	// Room for the two results one byte may cause.
	assign space_ok   = (count_q <= QCNT_W'(QDEPTH - 2));
	assign head_valid = (count_q != '0);
	assign head       = q_mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push_cnt != 2'd0) begin
			q_mem_q[wr_ptr_q] <= push0;
		end
		if (push_cnt == 2'd2) begin
			q_mem_q[wr_ptr_nx] <= push1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QPTR_W'(push_cnt);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + QCNT_W'(push_cnt) - QCNT_W'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push_cnt != 2'd0) |-> (count_q + QCNT_W'(push_cnt) <= QCNT_W'(QDEPTH)))
		else $error("result queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (count_q != '0))
		else $error("result queue read while empty");

	a_ptr_count: assert property (@(posedge clk) disable iff (!arst_n)
		(QPTR_W'(wr_ptr_q - rd_ptr_q) == count_q[QPTR_W-1:0]))
		else $error("result queue pointers disagree with fill count");

endmodule

// ===== tb/sv/le_adv_report_parser_tb.sv =====
module le_adv_report_parser_tb;

	import leadv_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int LONG_HOLD   = 300;
	localparam int SETTLE      = 4;

	typedef enum {
		PK_GOOD,
		PK_CUT,
		PK_BADHDR,
		PK_NOISE,
		PK_OPEN
	} pkt_shape_t;

	typedef struct {
		logic [7:0] b;
		logic       last;
	} hci_byte_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_data = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [95:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	le_adv_report_parser DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast)
	);

	// Bytes waiting to be offered, and report results still to arrive.
	hci_byte_t tx_bytes [$];
	result_t   due_results [$];

	int  bytes_queued = 0;
	int  bytes_accepted = 0;
	int  mismatches = 0;
	int  cycles = 0;
	bit  idle_on = 1'b1;
	bit  tx_taken = 1'b0;
	int  tx_gap = 0;
	int  rx_gap = 0;
	int  rx_hold = 0;
	int  hold_asks = 0;
	int  hold_seen = 0;

	// Parser state as the block should hold it.
	bit          scan_en = 1'b0;
	int          pkt_pos = 0;
	bit          pkt_bad = 1'b0;
	logic [3:0]  rpt_total = '0;
	logic [3:0]  rpt_idx = '0;
	int          fld_pos = 0;
	logic [7:0]  cap_adv = '0;
	logic [7:0]  cap_atype = '0;
	logic [47:0] cap_addr = '0;
	logic [7:0]  cap_len = '0;
	bit          rpts_complete = 1'b0;

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	function automatic void clear_packet_state();
		pkt_pos = 0;
		pkt_bad = 1'b0;
		rpt_total = '0;
		rpt_idx = '0;
		fld_pos = 0;
		rpts_complete = 1'b0;
	endfunction

	function automatic result_t snapshot(kind_t k, logic [7:0] dv, logic [7:0] rs);
		result_t r;
		r.kind = k;
		r.data_value = dv;
		r.report_index = rpt_idx;
		r.evt_type = cap_adv;
		r.peer_atype = cap_atype;
		r.address = cap_addr;
		r.rssi = rs;
		r.payload_len = cap_len;
		r.run_last = 1'b0;
		return r;
	endfunction

	task automatic parse_byte(input logic [7:0] b, input logic last);
		result_t outs [$];
		int p;
		int fp;
		if (!scan_en)
			return;
		if (pkt_pos < MAX_PACKET) begin
			p = pkt_pos;
			pkt_pos = p + 1;
			if (!pkt_bad) begin
				if (p == POS_IND) begin
					pkt_bad = (b != PKT_EVENT);
				end else if (p == POS_EVT) begin
					pkt_bad = (b != EVT_LE_META);
				end else if (p == POS_SUB) begin
					pkt_bad = (b != SUB_ADV_REPORT);
				end else if (p == POS_NUM) begin
					if (b == 8'd0 || b > MAX_REPORTS)
						pkt_bad = 1'b1;
					else
						rpt_total = b[3:0];
				end else if (p >= POS_REPORTS && !rpts_complete) begin
					fp = fld_pos;
					fld_pos = fp + 1;
					if (fp == FP_ADV) begin
						cap_adv = b;
						cap_atype = '0;
						cap_addr = '0;
						cap_len = '0;
					end else if (fp == FP_ATYPE) begin
						cap_atype = b;
					end else if (fp <= FP_ADDR_N) begin
						cap_addr[8 * (fp - FP_ADDR0) +: 8] = b;
					end else if (fp == FP_LEN) begin
						cap_len = b;
					end else if (fp < FP_DATA + int'(cap_len)) begin
						outs.push_back(snapshot(KIND_DATA, b, 8'h00));
					end else begin
						// RSSI byte. A packet ending here before the minimum
						// length turns the record into a discard.
						if (last && p + 1 < MIN_PACKET)
							outs.push_back(snapshot(KIND_DISCARD, 8'h00, 8'h00));
						else
							outs.push_back(snapshot(KIND_REPORT, 8'h00, b));
						fld_pos = 0;
						rpt_idx = rpt_idx + 4'd1;
						if (rpt_idx >= rpt_total)
							rpts_complete = 1'b1;
					end
				end
			end
		end
		if (last) begin
			if (!pkt_bad && !rpts_complete && fld_pos != 0)
				outs.push_back(snapshot(KIND_DISCARD, 8'h00, 8'h00));
			clear_packet_state();
		end
		if (outs.size() > 0)
			outs[outs.size() - 1].run_last = 1'b1;
		foreach (outs[i])
			due_results.push_back(outs[i]);
	endtask

	task automatic cmp_field(input string fname, input logic [47:0] want,
	                         input logic [47:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", fname, want, got);
			mismatches++;
		end
	endtask

	task automatic check_result(input result_t want);
		cmp_field("kind", 48'(want.kind), 48'(m_tuser));
		cmp_field("data_value", 48'(want.data_value), 48'(m_tdata[7:0]));
		cmp_field("report_index", 48'(want.report_index), 48'(m_tdata[11:8]));
		cmp_field("evt_type", 48'(want.evt_type), 48'(m_tdata[19:12]));
		cmp_field("peer_atype", 48'(want.peer_atype), 48'(m_tdata[27:20]));
		cmp_field("address", want.address, m_tdata[75:28]);
		cmp_field("rssi", 48'($unsigned(want.rssi)), 48'(m_tdata[83:76]));
		cmp_field("payload_len", 48'(want.payload_len), 48'(m_tdata[91:84]));
		cmp_field("run_last", 48'(want.run_last), 48'(m_tlast));
	endtask

	// Monitor: checks results, and predicts from every accepted byte and
	// register write.
	always @(posedge clk) begin
		result_t want;
		tx_taken = s_tvalid && s_tready;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (due_results.size() == 0) begin
					$error("result with nothing expected: kind %0d, data %0h",
					       m_tuser, m_tdata);
					mismatches++;
				end else begin
					want = due_results.pop_front();
					check_result(want);
				end
			end
			if (cfg_valid && cfg_ready) begin
				scan_en = cfg_data;
				clear_packet_state();
			end
			if (tx_taken) begin
				parse_byte(s_tdata, s_tlast);
				bytes_accepted++;
			end
		end
	end

	// Sender: offers queued bytes, with random idle bursts.
	always @(negedge clk) begin
		hci_byte_t it;
		if (s_tvalid && !tx_taken) begin
			// The current transfer has not completed; hold it.
		end else if (tx_gap > 0) begin
			tx_gap--;
			s_tvalid <= 1'b0;
		end else if (idle_on && $urandom_range(0, 15) == 0) begin
			tx_gap = $urandom_range(1, 14) - 1;
			s_tvalid <= 1'b0;
		end else if (tx_bytes.size() > 0) begin
			it = tx_bytes.pop_front();
			s_tvalid <= 1'b1;
			s_tdata <= it.b;
			s_tlast <= it.last;
		end else begin
			s_tvalid <= 1'b0;
		end
	end

	// Receiver: random stall bursts, plus a long hold-off on request.
	always @(negedge clk) begin
		if (hold_seen != hold_asks) begin
			hold_seen = hold_asks;
			rx_hold = LONG_HOLD;
		end
		if (rx_hold > 0) begin
			rx_hold--;
			m_tready <= 1'b0;
		end else if (rx_gap > 0) begin
			rx_gap--;
			m_tready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			rx_gap = $urandom_range(1, 14) - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$error("run did not finish within %0d cycles", CYCLE_LIMIT);
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic queue_byte(input logic [7:0] b, input logic last);
		hci_byte_t it;
		it.b = b;
		it.last = last;
		tx_bytes.push_back(it);
		bytes_queued++;
	endtask

	task automatic queue_packet(input int n_rep, input int min_len, input int max_len,
	                            input pkt_shape_t shape);
		logic [7:0] pkt [$];
		int len;
		int cut;
		pkt.push_back(PKT_EVENT);
		pkt.push_back(EVT_LE_META);
		pkt.push_back(8'($urandom));
		pkt.push_back(SUB_ADV_REPORT);
		pkt.push_back(8'(n_rep));
		for (int r = 0; r < n_rep; r++) begin
			repeat (2 + ADDR_BYTES)
				pkt.push_back(8'($urandom));
			len = $urandom_range(min_len, max_len);
			pkt.push_back(8'(len));
			repeat (len + 1)
				pkt.push_back(8'($urandom));
		end
		case (shape)
			PK_GOOD: begin
				if ($urandom_range(0, 3) == 0)
					repeat ($urandom_range(1, 3))
						pkt.push_back(8'($urandom));
			end
			PK_CUT: begin
				cut = $urandom_range(POS_REPORTS + 1, pkt.size() - 1);
				while (pkt.size() > cut)
					void'(pkt.pop_back());
			end
			PK_BADHDR: begin
				case ($urandom_range(0, 3))
					0: pkt[POS_IND] = pkt[POS_IND] ^ 8'($urandom_range(1, 255));
					1: pkt[POS_EVT] = pkt[POS_EVT] ^ 8'($urandom_range(1, 255));
					2: pkt[POS_SUB] = pkt[POS_SUB] ^ 8'($urandom_range(1, 255));
					default: begin
						pkt[POS_NUM] = $urandom_range(0, 1) ? 8'h00
						                                    : 8'($urandom_range(16, 255));
					end
				endcase
			end
			PK_NOISE: begin
				pkt.delete();
				repeat ($urandom_range(1, 8))
					pkt.push_back(8'($urandom));
			end
			default: begin
			end
		endcase
		foreach (pkt[i])
			queue_byte(pkt[i], shape != PK_OPEN && i == pkt.size() - 1);
	endtask

	task automatic queue_random_packet();
		int sel;
		int n_rep;
		sel = $urandom_range(0, 99);
		n_rep = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 15) : $urandom_range(1, 3);
		if (sel < 60)
			queue_packet(n_rep, 0, (n_rep > 4) ? 2 : 8, PK_GOOD);
		else if (sel < 78)
			queue_packet(n_rep, 0, (n_rep > 4) ? 2 : 8, PK_CUT);
		else if (sel < 92)
			queue_packet(n_rep, 0, 4, PK_BADHDR);
		else
			queue_packet(n_rep, 0, 4, PK_NOISE);
	endtask

	task automatic queue_random_bytes(input int n);
		int first;
		first = bytes_queued;
		while (bytes_queued - first < n)
			queue_random_packet();
	endtask

	// Waits until every byte has been taken and every result has arrived,
	// then leaves time for a byte that causes no result to pass through.
	task automatic wait_drained();
		while (bytes_accepted != bytes_queued || due_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_enable(input logic en);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= en;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Disabled after reset: a whole packet and a cut one pass unseen.
		queue_packet(1, 0, 4, PK_GOOD);
		queue_packet(1, 0, 4, PK_CUT);
		wait_drained();
		write_enable(1'b1);

		// Shortest report, ended on its RSSI: the record becomes a discard.
		queue_byte(PKT_EVENT, 1'b0);
		queue_byte(EVT_LE_META, 1'b0);
		queue_byte(8'hFF, 1'b0);
		queue_byte(SUB_ADV_REPORT, 1'b0);
		queue_byte(8'h01, 1'b0);
		queue_byte(8'hFF, 1'b0);
		queue_byte(8'h00, 1'b0);
		for (int i = 0; i < ADDR_BYTES; i++)
			queue_byte((i % 2) ? 8'hFF : 8'h00, 1'b0);
		queue_byte(8'h00, 1'b0);
		queue_byte(8'h80, 1'b1);
		// Wrong packet indicator on a one-byte packet.
		queue_byte(8'hFF, 1'b1);
		// Report count above fifteen.
		queue_byte(PKT_EVENT, 1'b0);
		queue_byte(EVT_LE_META, 1'b0);
		queue_byte(8'h00, 1'b0);
		queue_byte(SUB_ADV_REPORT, 1'b0);
		queue_byte(8'h10, 1'b1);
		// Report cut off after its address type.
		queue_byte(PKT_EVENT, 1'b0);
		queue_byte(EVT_LE_META, 1'b0);
		queue_byte(8'h7F, 1'b0);
		queue_byte(SUB_ADV_REPORT, 1'b0);
		queue_byte(8'h01, 1'b0);
		queue_byte(8'h7F, 1'b0);
		queue_byte(8'h01, 1'b1);
		wait_drained();

		// The receiver holds off for a long stretch while bytes keep coming.
		repeat (2) queue_random_packet();
		hold_asks++;
		queue_packet(2, 4, 8, PK_GOOD);
		queue_random_bytes(20);
		wait_drained();

		// A packet left open is cleared by a register write.
		queue_packet(1, 0, 6, PK_OPEN);
		wait_drained();
		write_enable(1'b1);
		write_enable(1'b0);
		queue_random_bytes(20);
		wait_drained();
		write_enable(1'b1);

		// Oversize packet: its RSSI falls past the limit, so the end mark
		// discards the report.
		queue_packet(1, MAX_PACKET - 14, 255, PK_GOOD);
		wait_drained();

		idle_on = 1'b0;
		queue_random_bytes(50);
		wait_drained();

		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
